[rtl/pfr_pkg.sv]
// Shared types and constants for the page frame replacement block.
package pfr_pkg;

  // Field widths fixed by the interface
  localparam int PAGE_W     = 16;
  localparam int FTYPE_W    = 3;
  localparam int PHYS_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int CHANCE_W   = 2;
  localparam int OUT_TDATA_W = 64;

  // Page shift limits
  localparam logic [4:0] SHIFT_MIN = 5'd8;
  localparam logic [4:0] SHIFT_MAX = 5'd16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT  = 2'd2;

  // Fault type codes
  localparam logic [FTYPE_W-1:0] FT_READ_FILL   = 3'd0;
  localparam logic [FTYPE_W-1:0] FT_WRITE_FILL  = 3'd1;
  localparam logic [FTYPE_W-1:0] FT_UPGRADE     = 3'd2;
  localparam logic [FTYPE_W-1:0] FT_READ_REREF  = 3'd3;
  localparam logic [FTYPE_W-1:0] FT_WRITE_REREF = 3'd4;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP,
    ST_EVICT
  } state_t;

  // Datapath commands, one per cycle
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_NEXT,
    CMD_FILL,
    CMD_UPGRADE,
    CMD_REREF,
    CMD_WRAP,
    CMD_SWEEP,
    CMD_SEEK,
    CMD_EVICT
  } cmd_t;

  // Datapath status towards the controller
  typedef struct packed {
    logic cur_valid;   // frame under scan holds a page
    logic cur_match;   // frame under scan holds the faulting page
    logic need_upg;    // write to a read-only resident page
    logic is_last;     // frame under scan is the last one in use
    logic clock_mode;  // third chance policy selected
    logic sweep_stop;  // frame under the hand is the victim
    logic out_free;    // output register can take a result
  } status_t;

endpackage

[rtl/pfr_ctrl.sv]
// Controller state machine: frame scan, clock sweep and eviction sequencing.
module pfr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  pfr_pkg::status_t st,
  output pfr_pkg::cmd_t    cmd
);

  pfr_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = pfr_pkg::CMD_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      pfr_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd       = pfr_pkg::CMD_LOAD;
          state_nxt = pfr_pkg::ST_SCAN;
        end
      end
      pfr_pkg::ST_SCAN: begin
        if (!st.cur_valid) begin
          // empty frame: fill it
          if (st.out_free) begin
            cmd       = pfr_pkg::CMD_FILL;
            state_nxt = pfr_pkg::ST_IDLE;
          end
        end else if (st.cur_match) begin
          if (st.need_upg) begin
            if (st.out_free) begin
              cmd       = pfr_pkg::CMD_UPGRADE;
              state_nxt = pfr_pkg::ST_IDLE;
            end
          end else if (st.clock_mode) begin
            if (st.out_free) begin
              cmd       = pfr_pkg::CMD_REREF;
              state_nxt = pfr_pkg::ST_IDLE;
            end
          end else begin
            // plain hit in fifo mode: nothing to report
            state_nxt = pfr_pkg::ST_IDLE;
          end
        end else if (st.is_last) begin
          cmd       = pfr_pkg::CMD_WRAP;
          state_nxt = st.clock_mode ? pfr_pkg::ST_SWEEP : pfr_pkg::ST_EVICT;
        end else begin
          cmd = pfr_pkg::CMD_NEXT;
        end
      end
      pfr_pkg::ST_SWEEP: begin
        if (st.sweep_stop) begin
          cmd       = pfr_pkg::CMD_SEEK;
          state_nxt = pfr_pkg::ST_EVICT;
        end else begin
          cmd = pfr_pkg::CMD_SWEEP;
        end
      end
      pfr_pkg::ST_EVICT: begin
        if (st.out_free) begin
          cmd       = pfr_pkg::CMD_EVICT;
          state_nxt = pfr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pfr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/pfr_datapath.sv]
// Datapath: frame table, clock hand, configuration and result register.
module pfr_datapath #(
  parameter int MAX_FRAMES  = 16,
  parameter int OFFSET_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pfr_pkg::cmd_t                       cmd,
  output pfr_pkg::status_t                    st,
  input  logic [OFFSET_BITS-1:0]              vm_offset,
  input  logic                                is_write,
  input  logic                                cfg_valid,
  input  logic [pfr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pfr_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pfr_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int FW    = $clog2(MAX_FRAMES);
  localparam int WORD_W = pfr_pkg::PAGE_W + 1;

  // Configuration registers
  logic                              policy_r;
  logic [pfr_pkg::CFG_DATA_W-1:0]    frame_count_r;
  logic [pfr_pkg::CFG_DATA_W-1:0]    page_shift_r;

  // Item registers
  logic [pfr_pkg::PAGE_W-1:0]        page_r;
  logic [15:0]                       inpage_r;
  logic [4:0]                        shift_r;
  logic                              wr_r;

  // Frame table
  logic [WORD_W-1:0]                 mem [MAX_FRAMES];   // {dirty, page}
  logic [WORD_W-1:0]                 rdata_r;
  logic [MAX_FRAMES-1:0]             valid_r;
  logic [MAX_FRAMES-1:0]             ref_r;
  logic [MAX_FRAMES-1:0]             writable_r;
  logic [pfr_pkg::CHANCE_W-1:0]      chance_r [MAX_FRAMES];

  logic [FW-1:0]                     idx_r;
  logic [FW-1:0]                     hand_r, hand_nxt;
  logic [FW-1:0]                     last_idx;
  logic [FW-1:0]                     rd_addr;
  logic                              rd_en;
  logic [4:0]                        shift_c;
  logic [OFFSET_BITS-1:0]            page_full;
  logic [15:0]                       inpage_c;

  // Result register
  logic                              out_valid_r, out_valid_nxt;
  logic [pfr_pkg::PAGE_W-1:0]        o_page_r;
  logic [pfr_pkg::FTYPE_W-1:0]       o_ftype_r;
  logic                              o_ev_r;
  logic [pfr_pkg::PAGE_W-1:0]        o_evpage_r;
  logic                              o_wb_r;
  logic [pfr_pkg::PHYS_W-1:0]        o_phys_r;

  logic                              emit;
  logic [FW-1:0]                     emit_frame;
  logic [31:0]                       phys_c;
  logic [pfr_pkg::FTYPE_W-1:0]       fill_type;
  logic                              hand_stop;
  logic [pfr_pkg::CHANCE_W-1:0]      hand_ch;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r      <= 1'b1;
      frame_count_r <= 5'd16;
      page_shift_r  <= 5'd12;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pfr_pkg::CFG_POLICY:      policy_r      <= cfg_data[0];
        pfr_pkg::CFG_FRAME_COUNT: frame_count_r <= cfg_data;
        pfr_pkg::CFG_PAGE_SHIFT:  page_shift_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Last frame in use, frame count clamped to 1..MAX_FRAMES
  always_comb begin
    if (frame_count_r == '0) begin
      last_idx = '0;
    end else if (32'(frame_count_r) > MAX_FRAMES) begin
      last_idx = FW'(MAX_FRAMES - 1);
    end else begin
      last_idx = FW'(32'(frame_count_r) - 32'd1);
    end
  end

  // Page split of the incoming offset
  always_comb begin
    if (page_shift_r < pfr_pkg::SHIFT_MIN) begin
      shift_c = pfr_pkg::SHIFT_MIN;
    end else if (page_shift_r > pfr_pkg::SHIFT_MAX) begin
      shift_c = pfr_pkg::SHIFT_MAX;
    end else begin
      shift_c = page_shift_r;
    end
    page_full = vm_offset >> shift_c;
    inpage_c  = vm_offset[15:0] & 16'((17'd1 << shift_c) - 17'd1);
  end

  always_ff @(posedge clk) begin
    if (cmd == pfr_pkg::CMD_LOAD) begin
      page_r   <= page_full[pfr_pkg::PAGE_W-1:0];
      inpage_r <= inpage_c;
      shift_r  <= shift_c;
      wr_r     <= is_write;
    end
  end

  // Scan index
  always_ff @(posedge clk) begin
    if (cmd == pfr_pkg::CMD_LOAD) begin
      idx_r <= '0;
    end else if (cmd == pfr_pkg::CMD_NEXT) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // Clock hand
  assign hand_ch   = chance_r[hand_r];
  assign hand_stop = !ref_r[hand_r] &&
                     ((!writable_r[hand_r] && hand_ch >= 2'd1) ||
                      (writable_r[hand_r] && hand_ch >= 2'd2));

  always_comb begin
    hand_nxt = hand_r;
    case (cmd)
      pfr_pkg::CMD_WRAP: begin
        if (hand_r > last_idx) hand_nxt = '0;
      end
      pfr_pkg::CMD_SWEEP, pfr_pkg::CMD_EVICT: begin
        hand_nxt = (hand_r >= last_idx) ? '0 : hand_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hand_r <= '0;
    end else begin
      hand_r <= hand_nxt;
    end
  end

  // Frame memory read port: registered, enabled only when data is wanted
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = hand_nxt;
    case (cmd)
      pfr_pkg::CMD_LOAD: rd_addr = '0;
      pfr_pkg::CMD_NEXT: rd_addr = idx_r + 1'b1;
      pfr_pkg::CMD_WRAP, pfr_pkg::CMD_SWEEP, pfr_pkg::CMD_SEEK: ;
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
    case (cmd)
      pfr_pkg::CMD_FILL:    mem[idx_r]  <= {wr_r, page_r};
      pfr_pkg::CMD_UPGRADE: mem[idx_r]  <= {1'b1, page_r};
      pfr_pkg::CMD_EVICT:   mem[hand_r] <= {wr_r, page_r};
      default: ;
    endcase
  end

  // Per-frame flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ref_r   <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) chance_r[i] <= '0;
    end else begin
      case (cmd)
        pfr_pkg::CMD_FILL: begin
          valid_r[idx_r]  <= 1'b1;
          ref_r[idx_r]    <= 1'b1;
          chance_r[idx_r] <= '0;
        end
        pfr_pkg::CMD_UPGRADE: begin
          if (policy_r) begin
            ref_r[idx_r]    <= 1'b1;
            chance_r[idx_r] <= '0;
          end
        end
        pfr_pkg::CMD_REREF: begin
          ref_r[idx_r]    <= 1'b1;
          chance_r[idx_r] <= '0;
        end
        pfr_pkg::CMD_SWEEP: begin
          ref_r[hand_r] <= 1'b0;
          if (hand_ch != 2'd3) chance_r[hand_r] <= hand_ch + 2'd1;
        end
        pfr_pkg::CMD_EVICT: begin
          valid_r[hand_r]  <= 1'b1;
          ref_r[hand_r]    <= 1'b1;
          chance_r[hand_r] <= '0;
        end
        default: ;
      endcase
    end
  end

  // Writable flags hold no meaning until their frame is filled
  always_ff @(posedge clk) begin
    case (cmd)
      pfr_pkg::CMD_FILL:    writable_r[idx_r]  <= wr_r;
      pfr_pkg::CMD_UPGRADE: writable_r[idx_r]  <= 1'b1;
      pfr_pkg::CMD_EVICT:   writable_r[hand_r] <= wr_r;
      default: ;
    endcase
  end

  // Result assembly
  assign fill_type  = wr_r ? pfr_pkg::FT_WRITE_FILL : pfr_pkg::FT_READ_FILL;
  assign emit       = (cmd == pfr_pkg::CMD_FILL) || (cmd == pfr_pkg::CMD_UPGRADE) ||
                      (cmd == pfr_pkg::CMD_REREF) || (cmd == pfr_pkg::CMD_EVICT);
  assign emit_frame = (cmd == pfr_pkg::CMD_EVICT) ? hand_r : idx_r;
  assign phys_c     = 32'(inpage_r) | (32'(emit_frame) << shift_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_page_r   <= page_r;
      o_phys_r   <= phys_c[pfr_pkg::PHYS_W-1:0];
      o_ev_r     <= (cmd == pfr_pkg::CMD_EVICT);
      o_evpage_r <= (cmd == pfr_pkg::CMD_EVICT) ? rdata_r[pfr_pkg::PAGE_W-1:0] : '0;
      o_wb_r     <= (cmd == pfr_pkg::CMD_EVICT) ? rdata_r[WORD_W-1] : 1'b0;
      case (cmd)
        pfr_pkg::CMD_UPGRADE: o_ftype_r <= pfr_pkg::FT_UPGRADE;
        pfr_pkg::CMD_REREF:
          o_ftype_r <= wr_r ? pfr_pkg::FT_WRITE_REREF : pfr_pkg::FT_READ_REREF;
        default:              o_ftype_r <= fill_type;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, o_phys_r, o_wb_r, o_evpage_r, o_ev_r, o_ftype_r, o_page_r};

  // Status towards the controller
  assign st.cur_valid  = valid_r[idx_r];
  assign st.cur_match  = valid_r[idx_r] && (rdata_r[pfr_pkg::PAGE_W-1:0] == page_r);
  assign st.need_upg   = wr_r && !writable_r[idx_r];
  assign st.is_last    = (idx_r == last_idx);
  assign st.clock_mode = policy_r;
  assign st.sweep_stop = hand_stop;
  assign st.out_free   = !out_valid_r || out_tready;

endmodule

[rtl/page_frame_replacement.sv]
// Top level of the page frame replacement block.
// Usage:
//   in_*  : one page-fault event per transfer (offset into the managed region
//           and a read/write flag). Taken only while no event is in work.
//   out_* : at most one result per event (page, fault type, evicted page,
//           write-back flag, physical address). A fifo-mode hit gives none.
//   cfg_* : register writes (policy, frame count, page shift); always ready.
//           Written only while the block is idle: a user rule, not enforced.
// Flow: the event is taken, then the frames in use are scanned in order
//   until a match or an empty frame. With the table full, fifo mode evicts
//   the frame under the clock hand; third chance mode first sweeps the hand
//   until it stops at a victim, then evicts it. The frame scan over the
//   frame memory's single read port sets the pace; one event is in work at
//   a time.
// Reset: all frames empty, hand at frame 0, policy third chance, 16 frames,
//   4 KiB pages. No clearing pass is needed.
// Stall: the result sits in an output register; a new event is taken while
//   it waits, and the following result waits in the controller until the
//   register is free.
module page_frame_replacement #(
  parameter int MAX_FRAMES  = 16,
  parameter int OFFSET_BITS = 24
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // tdata, low bit up: vm_offset, is_write, zero fill
  input  logic [((OFFSET_BITS + 8) / 8) * 8 - 1:0]   in_tdata,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  // tdata, low bit up: page_number[15:0], fault_type[18:16],
  // evicted_valid[19], evicted_page[35:20], write_back[36],
  // physical address[56:37], zero fill
  output logic [pfr_pkg::OUT_TDATA_W-1:0]            out_tdata,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [pfr_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [pfr_pkg::CFG_DATA_W-1:0]             cfg_data
);

  pfr_pkg::status_t st;
  pfr_pkg::cmd_t    cmd;

  assign cfg_ready = 1'b1;

  pfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  pfr_datapath #(
    .MAX_FRAMES  (MAX_FRAMES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .vm_offset  (in_tdata[OFFSET_BITS-1:0]),
    .is_write   (in_tdata[OFFSET_BITS]),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the page frame replacement block.
module tb_top;

  localparam int PAGE_W       = pfr_pkg::PAGE_W;
  localparam int FTYPE_W      = pfr_pkg::FTYPE_W;
  localparam int PHYS_W       = pfr_pkg::PHYS_W;
  localparam int CFG_IDX_W    = pfr_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W   = pfr_pkg::CFG_DATA_W;
  localparam int CHANCE_W     = pfr_pkg::CHANCE_W;
  localparam int OUT_TDATA_W  = pfr_pkg::OUT_TDATA_W;
  localparam int IN_TDATA_W   = 32;
  localparam int TABLE_FRAMES = 16;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int SWEEP_GUARD  = 3 * TABLE_FRAMES + 1;
  localparam int N_PHASES     = 14;
  localparam int PHASE_ITEMS  = 125;

  // One fault report as it leaves the block
  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    logic [FTYPE_W-1:0] ftype;
    logic               ev;
    logic [PAGE_W-1:0]  evpage;
    logic               wb;
    logic [PHYS_W-1:0]  phys;
  } fault_rpt_t;

  // Directed plan: register writes, faults checked by the predictor, and
  // faults whose report is typed in
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_FAULT,
    ROW_TYPED
  } row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_DATA_W-1:0]   reg_val;
    logic [23:0]             offset;
    logic                    wr;
    fault_rpt_t              want;
  } plan_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  // Predictor copy of the registers and the frame table
  logic                    shadow_policy = 1'b1;
  logic [CFG_DATA_W-1:0]   shadow_count  = 5'd16;
  logic [CFG_DATA_W-1:0]   shadow_shift  = 5'd12;
  logic [PAGE_W-1:0]       res_page     [TABLE_FRAMES];
  bit                      res_valid    [TABLE_FRAMES];
  bit                      res_writable [TABLE_FRAMES];
  bit                      res_dirty    [TABLE_FRAMES];
  bit                      res_ref      [TABLE_FRAMES];
  logic [CHANCE_W-1:0]     res_chance   [TABLE_FRAMES];
  int unsigned             hand_pos = 0;

  fault_rpt_t              pending_rpts [$];
  int unsigned             n_mismatch = 0;
  bit                      send_gaps = 1'b1;
  bit                      recv_gaps = 1'b1;
  bit                      hold_long = 1'b0;

  plan_row_t plan [34] = '{
    // empty table, reset settings: fills, upgrade and both re-references
    '{ROW_TYPED, '0, '0, 24'h000000, 1'b0,
      '{16'h0000, pfr_pkg::FT_READ_FILL, 1'b0, 16'h0000, 1'b0, 20'h00000}},
    '{ROW_TYPED, '0, '0, 24'hFFFFFF, 1'b1,
      '{16'h0FFF, pfr_pkg::FT_WRITE_FILL, 1'b0, 16'h0000, 1'b0, 20'h01FFF}},
    '{ROW_TYPED, '0, '0, 24'h000123, 1'b1,
      '{16'h0000, pfr_pkg::FT_UPGRADE, 1'b0, 16'h0000, 1'b0, 20'h00123}},
    '{ROW_TYPED, '0, '0, 24'h000456, 1'b0,
      '{16'h0000, pfr_pkg::FT_READ_REREF, 1'b0, 16'h0000, 1'b0, 20'h00456}},
    '{ROW_TYPED, '0, '0, 24'hFFF001, 1'b1,
      '{16'h0FFF, pfr_pkg::FT_WRITE_REREF, 1'b0, 16'h0000, 1'b0, 20'h01001}},
    // two full frames: clock sweep evictions
    '{ROW_CFG, pfr_pkg::CFG_FRAME_COUNT, 5'd2, 24'h0, 1'b0, '0},
    '{ROW_FAULT, '0, '0, 24'h005000, 1'b0, '0},
    '{ROW_FAULT, '0, '0, 24'h006000, 1'b1, '0},
    '{ROW_FAULT, '0, '0, 24'h005ABC, 1'b0, '0},
    '{ROW_FAULT, '0, '0, 24'h007000, 1'b1, '0},
    '{ROW_FAULT, '0, '0, 24'h006FFF, 1'b1, '0},
    // fifo: hits give nothing, round robin eviction, upgrade
    '{ROW_CFG, pfr_pkg::CFG_POLICY, 5'd0, 24'h0, 1'b0, '0},
    '{ROW_FAULT, '0, '0, 24'h007111, 1'b0, '0},
    '{ROW_FAULT, '0, '0, 24'h007222, 1'b1, '0},
    '{ROW_FAULT, '0, '0, 24'h008000, 1'b0, '0},
    '{ROW_FAULT, '0, '0, 24'h008010, 1'b1, '0},
    '{ROW_FAULT, '0, '0, 24'h009000, 1'b1, '0},
    // frame count and page shift below range
    '{ROW_CFG, pfr_pkg::CFG_FRAME_COUNT, 5'd0, 24'h0, 1'b0, '0},
    '{ROW_CFG, pfr_pkg::CFG_PAGE_SHIFT, 5'd0, 24'h0, 1'b0, '0},
    '{ROW_FAULT, '0, '0, 24'hFFFFFF, 1'b0, '0},
    '{ROW_FAULT, '0, '0, 24'h0000FF, 1'b1, '0},
    // and above range, with the hand left beyond the old count
    '{ROW_CFG, pfr_pkg::CFG_FRAME_COUNT, 5'd31, 24'h0, 1'b0, '0},
    '{ROW_CFG, pfr_pkg::CFG_PAGE_SHIFT, 5'd31, 24'h0, 1'b0, '0},
    '{ROW_FAULT, '0, '0, 24'hFFFFFF, 1'b1, '0},
    '{ROW_FAULT, '0, '0, 24'h000000, 1'b0, '0},
    // largest pages under the clock policy
    '{ROW_CFG, pfr_pkg::CFG_POLICY, 5'd1, 24'h0, 1'b0, '0},
    '{ROW_CFG, pfr_pkg::CFG_PAGE_SHIFT, 5'd16, 24'h0, 1'b0, '0},
    '{ROW_FAULT, '0, '0, 24'h800000, 1'b0, '0},
    '{ROW_FAULT, '0, '0, 24'h7FFFFF, 1'b1, '0},
    '{ROW_FAULT, '0, '0, 24'hFFFFFF, 1'b0, '0},
    // smallest pages over the full table
    '{ROW_CFG, pfr_pkg::CFG_PAGE_SHIFT, 5'd8, 24'h0, 1'b0, '0},
    '{ROW_CFG, pfr_pkg::CFG_FRAME_COUNT, 5'd16, 24'h0, 1'b0, '0},
    '{ROW_FAULT, '0, '0, 24'hABCDEF, 1'b1, '0},
    '{ROW_FAULT, '0, '0, 24'h123456, 1'b0, '0}
  };

  page_frame_replacement uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    // tdata, low bit up: vm_offset[23:0], is_write[24], zero fill
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // tdata, low bit up: page_number, fault_type, evicted_valid,
    // evicted_page, write_back, physical address, zero fill
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

  // Effective page shift, clamped to the supported range
  function automatic int unsigned eff_shift(input logic [CFG_DATA_W-1:0] sh);
    if (sh < pfr_pkg::SHIFT_MIN) return pfr_pkg::SHIFT_MIN;
    if (sh > pfr_pkg::SHIFT_MAX) return pfr_pkg::SHIFT_MAX;
    return sh;
  endfunction

  // Frame table update for one fault; returns 1 when a report is due
  function automatic bit predict_fault(input logic [23:0] off, input logic wr,
                                       output fault_rpt_t r);
    int unsigned sh, cnt, inpg, f, i, g;
    logic [PAGE_W-1:0] pg;
    sh   = eff_shift(shadow_shift);
    cnt  = (shadow_count < 1) ? 1 :
           ((shadow_count > TABLE_FRAMES) ? TABLE_FRAMES : shadow_count);
    pg   = PAGE_W'(off >> sh);
    inpg = off & ((32'd1 << sh) - 1);
    r = '0;
    r.page = pg;

    // scan frames in order: first empty frame or matching page ends it
    for (i = 0; i < cnt; i++) begin
      if (!res_valid[i]) begin
        res_valid[i]    = 1'b1;
        res_page[i]     = pg;
        res_writable[i] = wr;
        res_dirty[i]    = wr;
        res_ref[i]      = 1'b1;
        res_chance[i]   = '0;
        r.ftype = wr ? pfr_pkg::FT_WRITE_FILL : pfr_pkg::FT_READ_FILL;
        r.phys  = PHYS_W'(inpg + (i << sh));
        return 1'b1;
      end
      if (res_page[i] == pg) begin
        r.phys = PHYS_W'(inpg + (i << sh));
        if (wr && !res_writable[i]) begin
          res_writable[i] = 1'b1;
          res_dirty[i]    = 1'b1;
          if (shadow_policy) begin
            res_ref[i]    = 1'b1;
            res_chance[i] = '0;
          end
          r.ftype = pfr_pkg::FT_UPGRADE;
          return 1'b1;
        end
        if (!shadow_policy) return 1'b0;   // fifo hit
        res_ref[i]    = 1'b1;
        res_chance[i] = '0;
        r.ftype = wr ? pfr_pkg::FT_WRITE_REREF : pfr_pkg::FT_READ_REREF;
        return 1'b1;
      end
    end

    // table full: sweep the hand (clock mode) then evict under it
    if (hand_pos >= cnt) hand_pos = 0;
    if (shadow_policy) begin
      for (g = 0; g < SWEEP_GUARD; g++) begin
        f = hand_pos;
        if (!res_ref[f] && ((!res_writable[f] && res_chance[f] >= 1) ||
                            (res_writable[f] && res_chance[f] >= 2)))
          break;
        if (res_chance[f] < 3) res_chance[f]++;
        res_ref[f] = 1'b0;
        hand_pos++;
        if (hand_pos >= cnt) hand_pos = 0;
      end
    end
    f = hand_pos;
    r.ftype  = wr ? pfr_pkg::FT_WRITE_FILL : pfr_pkg::FT_READ_FILL;
    r.ev     = 1'b1;
    r.evpage = res_page[f];
    r.wb     = res_dirty[f];
    r.phys   = PHYS_W'(inpg + (f << sh));
    res_page[f]     = pg;
    res_valid[f]    = 1'b1;
    res_writable[f] = wr;
    res_dirty[f]    = wr;
    res_ref[f]      = 1'b1;
    res_chance[f]   = '0;
    hand_pos++;
    if (hand_pos >= cnt) hand_pos = 0;
    return 1'b1;
  endfunction

  // Register write; valid is dropped by whatever drives next
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      pfr_pkg::CFG_POLICY:      shadow_policy = val[0];
      pfr_pkg::CFG_FRAME_COUNT: shadow_count  = val;
      pfr_pkg::CFG_PAGE_SHIFT:  shadow_shift  = val;
      default: ;
    endcase
  endtask

  // Offer one fault; on transfer, record the expected report
  task automatic send_fault(input logic [23:0] off, input logic wr,
                            input bit typed, input fault_rpt_t given);
    fault_rpt_t r;
    bit has;
    cfg_valid <= 1'b0;
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, wr, off};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    has = predict_fault(off, wr, r);
    if (typed) r = given;
    if (has || typed) pending_rpts.push_back(r);
  endtask

  // Wait for all reports, then let a silent hit finish its scan
  task automatic settle();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_rpts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random phase: new settings, then faults over a small page set
  task automatic run_phase(input logic pol, input logic [CFG_DATA_W-1:0] cnt,
                           input logic [CFG_DATA_W-1:0] sh, input int n,
                           input bit press);
    logic [PAGE_W-1:0] pool [$];
    int unsigned sh_e, n_pool;
    logic [23:0] off;
    logic wr;
    settle();
    write_reg(pfr_pkg::CFG_POLICY, {4'b0, pol});
    write_reg(pfr_pkg::CFG_FRAME_COUNT, cnt);
    write_reg(pfr_pkg::CFG_PAGE_SHIFT, sh);
    sh_e   = eff_shift(sh);
    n_pool = ((cnt < 1) ? 1 : ((cnt > TABLE_FRAMES) ? TABLE_FRAMES : cnt)) +
             $urandom_range(1, 3);
    repeat (n_pool) pool.push_back(PAGE_W'($urandom));
    if (press) hold_long = 1'b1;
    repeat (n) begin
      if ($urandom_range(0, 7) == 0)
        off = 24'($urandom);
      else
        off = 24'((pool[$urandom_range(0, n_pool - 1)] << sh_e) |
                  ($urandom & ((32'd1 << sh_e) - 1)));
      wr = ($urandom_range(0, 9) < 4);
      send_fault(off, wr, 1'b0, '0);
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_long = 1'b0;
      end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      n_mismatch++;
    end
  endtask

  // Compare every report transfer with the oldest expectation
  always @(posedge clk) begin
    fault_rpt_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_rpts.size() == 0) begin
        $error("report transfer with nothing expected: %0h", out_tdata);
        n_mismatch++;
      end else begin
        want = pending_rpts.pop_front();
        check_field("page_number",   want.page,   out_tdata[15:0]);
        check_field("fault_type",    want.ftype,  out_tdata[18:16]);
        check_field("evicted_valid", want.ev,     out_tdata[19]);
        check_field("evicted_page",  want.evpage, out_tdata[35:20]);
        check_field("write_back",    want.wb,     out_tdata[36]);
        check_field("phys_address",  want.phys,   out_tdata[56:37]);
      end
    end
  end

  // Main sequence
  initial begin
    logic pol;
    logic [CFG_DATA_W-1:0] cnt, sh;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed plan
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: begin
          settle();
          write_reg(plan[i].reg_idx, plan[i].reg_val);
        end
        ROW_TYPED: send_fault(plan[i].offset, plan[i].wr, 1'b1, plan[i].want);
        default:   send_fault(plan[i].offset, plan[i].wr, 1'b0, '0);
      endcase
    end

    // random phases; extremes first and last, no idling at the end
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 0) begin
        pol = 1'b1; cnt = 5'd1; sh = 5'd8;
      end else if (ph == N_PHASES - 1) begin
        pol = 1'b0; cnt = 5'd16; sh = 5'd16;
      end else begin
        pol = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
          0:       cnt = 5'($urandom_range(0, 31));
          1:       cnt = 5'd16;
          default: cnt = 5'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 5))
          0:       sh = 5'($urandom_range(0, 31));
          1:       sh = 5'd8;
          2:       sh = 5'd16;
          default: sh = 5'($urandom_range(9, 15));
        endcase
      end
      send_gaps = (ph < N_PHASES - 2) && (ph != 3) && ($urandom_range(0, 3) != 0);
      recv_gaps = (ph < N_PHASES - 2) && ($urandom_range(0, 3) != 0);
      run_phase(pol, cnt, sh, PHASE_ITEMS, ph == 3);
    end

    settle();
    if (n_mismatch == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/pfr_pkg.sv
rtl/pfr_ctrl.sv
rtl/pfr_datapath.sv
rtl/page_frame_replacement.sv
dv/tb_top.sv
